### sv/csaht_pkg.sv
// ----------------------------------------------------------------------------
// csaht_pkg
// Shared types and constants of the chained set-associative hash table.
// ----------------------------------------------------------------------------
package csaht_pkg;

  localparam int unsigned WAYS          = 8;
  localparam int unsigned TOTAL_BUCKETS = 512;
  localparam int unsigned SIZE_BITS     = 16;
  localparam int unsigned OFFSET_BITS   = 24;

  localparam int unsigned SLOT_COUNT = TOTAL_BUCKETS * WAYS;
  localparam int unsigned SLOT_W    = $clog2(SLOT_COUNT);
  localparam int unsigned BKT_W     = $clog2(TOTAL_BUCKETS);
  localparam int unsigned WAY_W     = $clog2(WAYS);
  localparam int unsigned VISIT_W   = $clog2(TOTAL_BUCKETS + 1);

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned MAIN_W  = 9;
  localparam int unsigned REGION_W = 25;
  localparam int unsigned REF_W   = SIZE_BITS + OFFSET_BITS;

  // output field widths
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned OSLOT_W = 12;
  localparam int unsigned OSIZE_W = 16;
  localparam int unsigned OOFF_W  = 24;

  localparam logic [MAIN_W-1:0]   MAIN_RESET   = 9'd448;
  localparam logic [REGION_W-1:0] REGION_RESET = 25'd16777216;

  typedef enum logic {
    CFG_MAIN   = 1'b0,
    CFG_REGION = 1'b1
  } cfg_idx_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_OVF_FULL  = 3'd4,
    ST_VAL_FULL  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_REF,
    S_REF_DATA,
    S_ALLOC,
    S_WRITE,
    S_RESP
  } state_e;

  // handshake between the control logic and the modulo unit
  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] rem;
  } mod_rsp_t;

endpackage

### sv/csaht_ram.sv
// ----------------------------------------------------------------------------
// csaht_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module csaht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/csaht_mod.sv
// ----------------------------------------------------------------------------
// csaht_mod
// Iterative key modulo bucket count, four key bits per cycle.
// ----------------------------------------------------------------------------
module csaht_mod (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [csaht_pkg::KEY_W-1:0]        key_i,
  input  logic [csaht_pkg::BKT_W-1:0]        divisor_i,
  output csaht_pkg::mod_rsp_t                rsp_o
);

  localparam int unsigned STEP   = 4;
  localparam int unsigned ROUNDS = csaht_pkg::KEY_W / STEP;
  localparam int unsigned CNT_W  = $clog2(ROUNDS + 1);

  logic [csaht_pkg::KEY_W-1:0] key_q, key_d;
  logic [csaht_pkg::BKT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  always_comb begin
    logic [csaht_pkg::BKT_W:0] r;
    r      = '0;
    key_d  = key_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      key_d  = key_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r = {1'b0, rem_q};
      for (int k = 0; k < STEP; k++) begin
        r = {r[csaht_pkg::BKT_W-1:0], key_q[csaht_pkg::KEY_W-1-k]};
        if (r >= {1'b0, divisor_i}) begin
          r = r - {1'b0, divisor_i};
        end
      end
      rem_d = r[csaht_pkg::BKT_W-1:0];
      key_d = key_q << STEP;
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ROUNDS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

### sv/chained_set_assoc_hash_table.sv
// ----------------------------------------------------------------------------
// chained_set_assoc_hash_table
// Hash table engine: set-associative buckets, overflow chaining, bump
// allocation of value space.
// ----------------------------------------------------------------------------
// Takes pre-hashed nonzero keys and either inserts them (reserving length+1
// bytes of value space) or looks them up, returning one result transaction
// per input transaction. After reset all 4096 slots of the key store are
// swept to zero, one slot per cycle; no input is taken during that sweep but
// configuration writes are. An item is then accepted, its key is reduced
// modulo the bucket count by the key-modulo unit (four bits a cycle), each
// slot visited is read from the key RAM one slot at a time through its
// registered read port, and the result is finished; the number of slots
// visited is bounded by the chain length.
// The output register lets one result wait while the next item is taken.
// Configuration should be written only while idle; the block does not enforce it.
module chained_set_assoc_hash_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [24:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // key[63:0], value_length[79:64]
  input  logic        s_axis_tuser,   // mode (0 insert, 1 lookup)
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // status[2:0], slot_index[14:3],
                                      // value_size[30:15], value_offset[54:31]
);

  localparam int unsigned SW = csaht_pkg::SLOT_W;
  localparam int unsigned BW = csaht_pkg::BKT_W;

  // configuration registers
  logic [csaht_pkg::MAIN_W-1:0]   main_q;
  logic [csaht_pkg::REGION_W-1:0] region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q   <= csaht_pkg::MAIN_RESET;
      region_q <= csaht_pkg::REGION_RESET;
    end else if (cfg_we_i) begin
      case (csaht_pkg::cfg_idx_e'(cfg_idx_i))
        csaht_pkg::CFG_MAIN:   main_q   <= cfg_data_i[csaht_pkg::MAIN_W-1:0];
        csaht_pkg::CFG_REGION: region_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective home bucket count, clamped to 1 .. TOTAL_BUCKETS-1
  logic [BW-1:0] m_eff;
  always_comb begin
    if (main_q == '0) begin
      m_eff = BW'(1);
    end else if (32'(main_q) > csaht_pkg::TOTAL_BUCKETS - 1) begin
      m_eff = BW'(csaht_pkg::TOTAL_BUCKETS - 1);
    end else begin
      m_eff = BW'(main_q);
    end
  end

  // allocation limit, capped at 2^OFFSET_BITS
  localparam logic [csaht_pkg::REGION_W:0] CAP = 26'(1) << csaht_pkg::OFFSET_BITS;
  logic [csaht_pkg::REGION_W:0] lim;
  assign lim = ({1'b0, region_q} > CAP) ? CAP : {1'b0, region_q};

  // state
  csaht_pkg::state_e state_q, state_d;
  logic [SW-1:0]                  clr_q, clr_d;
  logic                           mode_q, mode_d;
  logic [csaht_pkg::KEY_W-1:0]    key_q, key_d;
  logic [csaht_pkg::LEN_W-1:0]    len_q, len_d;
  logic [BW-1:0]                  bkt_q, bkt_d;
  logic [csaht_pkg::WAY_W-1:0]    way_q, way_d;
  logic [csaht_pkg::VISIT_W-1:0]  visits_q, visits_d;
  logic                           new_q, new_d;
  logic [SW-1:0]                  target_q, target_d;
  logic [BW-1:0]                  ovf_q, ovf_d;
  logic [csaht_pkg::REGION_W-1:0] fill_q, fill_d;
  logic [2:0]                     rst_q, rst_d;      // result status
  logic [csaht_pkg::OSLOT_W-1:0]  rslot_q, rslot_d;
  logic [csaht_pkg::OSIZE_W-1:0]  rsize_q, rsize_d;
  logic [csaht_pkg::OOFF_W-1:0]   roff_q, roff_d;
  logic                           ov_q, ov_d;        // output valid
  logic [55:0]                    od_q, od_d;

  // memories
  logic                        k_we;
  logic [SW-1:0]               k_waddr, k_raddr;
  logic [csaht_pkg::KEY_W-1:0] k_wdata, k_rdata;
  logic                        r_we;
  logic [csaht_pkg::REF_W-1:0] r_wdata, r_rdata;

  csaht_ram #(.Width(csaht_pkg::KEY_W), .Depth(csaht_pkg::SLOT_COUNT)) u_keys (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  // value refs: {offset, size}
  csaht_ram #(.Width(csaht_pkg::REF_W), .Depth(csaht_pkg::SLOT_COUNT)) u_refs (
    .clk_i, .we_i(r_we), .waddr_i(target_q), .wdata_i(r_wdata),
    .raddr_i(target_q), .rdata_o(r_rdata)
  );

  // key modulo unit, started the cycle after an item with a nonzero key is
  // taken, once key_q holds that key
  logic                start_q;
  csaht_pkg::mod_rsp_t mod_rsp;

  csaht_mod u_mod (
    .clk_i, .rst_ni, .start_i(start_q), .key_i(key_q),
    .divisor_i(m_eff), .rsp_o(mod_rsp)
  );

  // current slot and derived values
  logic [SW-1:0]     slot_cur, nb_base;
  logic [BW-1:0]     nb;
  logic [BW:0]       ovf_room;
  logic [16:0]       size;
  logic [csaht_pkg::REGION_W+1:0] fill_sum;

  assign slot_cur = SW'(bkt_q) * SW'(csaht_pkg::WAYS) + SW'(way_q);
  assign nb       = m_eff + ovf_q;
  assign nb_base  = SW'(nb) * SW'(csaht_pkg::WAYS);
  assign ovf_room = (BW+1)'(csaht_pkg::TOTAL_BUCKETS) - {1'b0, m_eff};
  assign size     = {1'b0, len_q} + 17'd1;
  assign fill_sum = {2'b00, fill_q} + 27'(size);
  assign r_wdata  = {csaht_pkg::OFFSET_BITS'(fill_q), csaht_pkg::SIZE_BITS'(size)};

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    mode_d   = mode_q;
    key_d    = key_q;
    len_d    = len_q;
    bkt_d    = bkt_q;
    way_d    = way_q;
    visits_d = visits_q;
    new_d    = new_q;
    target_d = target_q;
    ovf_d    = ovf_q;
    fill_d   = fill_q;
    rst_d    = rst_q;
    rslot_d  = rslot_q;
    rsize_d  = rsize_q;
    roff_d   = roff_q;
    ov_d     = ov_q;
    od_d     = od_q;
    k_we     = 1'b0;
    k_waddr  = clr_q;
    k_wdata  = '0;
    k_raddr  = slot_cur;
    r_we     = 1'b0;
    s_axis_tready = 1'b0;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      csaht_pkg::S_CLEAR: begin
        k_we  = 1'b1;
        clr_d = clr_q + SW'(1);
        if (clr_q == SW'(csaht_pkg::SLOT_COUNT - 1)) begin
          state_d = csaht_pkg::S_IDLE;
        end
      end
      csaht_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mode_d  = s_axis_tuser;
          key_d   = s_axis_tdata[63:0];
          len_d   = s_axis_tdata[79:64];
          rslot_d = '0;
          rsize_d = '0;
          roff_d  = '0;
          if (s_axis_tdata[63:0] == '0) begin
            // zero is the empty marker
            rst_d   = s_axis_tuser ? csaht_pkg::ST_NOT_FOUND : csaht_pkg::ST_DUPLICATE;
            state_d = csaht_pkg::S_RESP;
          end else begin
            state_d = csaht_pkg::S_MOD;
          end
        end
      end
      csaht_pkg::S_MOD: begin
        if (mod_rsp.done) begin
          bkt_d    = mod_rsp.rem;
          way_d    = '0;
          visits_d = csaht_pkg::VISIT_W'(1);
          new_d    = 1'b0;
          state_d  = csaht_pkg::S_READ;
        end
      end
      csaht_pkg::S_READ: begin
        state_d = csaht_pkg::S_CHECK;
      end
      csaht_pkg::S_CHECK: begin
        if (32'(way_q) < csaht_pkg::WAYS - 1) begin
          if (k_rdata == key_q) begin
            if (mode_q) begin
              target_d = slot_cur;
              state_d  = csaht_pkg::S_REF;
            end else begin
              rst_d   = csaht_pkg::ST_DUPLICATE;
              state_d = csaht_pkg::S_RESP;
            end
          end else if (k_rdata == '0 && !mode_q) begin
            target_d = slot_cur;
            state_d  = csaht_pkg::S_ALLOC;
          end else begin
            way_d   = way_q + csaht_pkg::WAY_W'(1);
            state_d = csaht_pkg::S_READ;
          end
        end else begin
          // link slot
          if (k_rdata == '0) begin
            if (mode_q) begin
              rst_d   = csaht_pkg::ST_NOT_FOUND;
              state_d = csaht_pkg::S_RESP;
            end else begin
              new_d    = 1'b1;
              target_d = slot_cur;          // link slot, rewritten in S_ALLOC
              state_d  = csaht_pkg::S_ALLOC;
            end
          end else if (32'(visits_q) >= csaht_pkg::TOTAL_BUCKETS ||
                       k_rdata[csaht_pkg::KEY_W-1:BW] != '0) begin
            rst_d   = mode_q ? csaht_pkg::ST_NOT_FOUND : csaht_pkg::ST_OVF_FULL;
            state_d = csaht_pkg::S_RESP;
          end else begin
            bkt_d    = k_rdata[BW-1:0];
            way_d    = '0;
            visits_d = visits_q + csaht_pkg::VISIT_W'(1);
            state_d  = csaht_pkg::S_READ;
          end
        end
      end
      csaht_pkg::S_REF: begin
        // ref read issued at target_q
        state_d = csaht_pkg::S_REF_DATA;
      end
      csaht_pkg::S_REF_DATA: begin
        rst_d   = csaht_pkg::ST_FOUND;
        rslot_d = csaht_pkg::OSLOT_W'(target_q);
        rsize_d = csaht_pkg::OSIZE_W'(r_rdata[csaht_pkg::SIZE_BITS-1:0]);
        roff_d  = csaht_pkg::OOFF_W'(r_rdata[csaht_pkg::REF_W-1:csaht_pkg::SIZE_BITS]);
        state_d = csaht_pkg::S_RESP;
      end
      csaht_pkg::S_ALLOC: begin
        if (new_q && {1'b0, ovf_q} >= ovf_room) begin
          rst_d   = csaht_pkg::ST_OVF_FULL;
          state_d = csaht_pkg::S_RESP;
        end else if (32'(size) > (32'(1) << csaht_pkg::SIZE_BITS) - 1 ||
                     fill_sum >= (csaht_pkg::REGION_W+2)'(lim)) begin
          rst_d   = csaht_pkg::ST_VAL_FULL;
          state_d = csaht_pkg::S_RESP;
        end else begin
          if (new_q) begin
            // hook a fresh overflow bucket onto the chain
            k_we     = 1'b1;
            k_waddr  = target_q;
            k_wdata  = csaht_pkg::KEY_W'(nb);
            ovf_d    = ovf_q + BW'(1);
            target_d = nb_base;
          end
          state_d = csaht_pkg::S_WRITE;
        end
      end
      csaht_pkg::S_WRITE: begin
        k_we    = 1'b1;
        k_waddr = target_q;
        k_wdata = key_q;
        r_we    = 1'b1;
        fill_d  = csaht_pkg::REGION_W'(fill_sum);
        rst_d   = csaht_pkg::ST_INSERTED;
        rslot_d = csaht_pkg::OSLOT_W'(target_q);
        rsize_d = csaht_pkg::OSIZE_W'(size);
        roff_d  = csaht_pkg::OOFF_W'(fill_q);
        state_d = csaht_pkg::S_RESP;
      end
      csaht_pkg::S_RESP: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          od_d    = {1'b0, roff_q, rsize_q, rslot_q, rst_q};
          state_d = csaht_pkg::S_IDLE;
        end
      end
      default: state_d = csaht_pkg::S_IDLE;
    endcase

    if (state_q == csaht_pkg::S_IDLE) begin
      visits_d = '0;
    end
  end

  // start pulse: first cycle in S_MOD after accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= s_axis_tready && s_axis_tvalid && (s_axis_tdata[63:0] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= csaht_pkg::S_CLEAR;
      clr_q    <= '0;
      ovf_q    <= '0;
      fill_q   <= '0;
      ov_q     <= 1'b0;
      visits_q <= '0;
      new_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ovf_q    <= ovf_d;
      fill_q   <= fill_d;
      ov_q     <= ov_d;
      visits_q <= visits_d;
      new_q    <= new_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    key_q    <= key_d;
    len_q    <= len_d;
    bkt_q    <= bkt_d;
    way_q    <= way_d;
    target_q <= target_d;
    rst_q    <= rst_d;
    rslot_q  <= rslot_d;
    rsize_q  <= rsize_d;
    roff_q   <= roff_d;
    od_q     <= od_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule

### dv/chained_set_assoc_hash_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_set_assoc_hash_table_test
// Self-checking bench: random inserts and lookups against an in-bench model.
// ----------------------------------------------------------------------------
// A driver feeds input transactions from a queue in random bursts; a monitor
// with its own stall pattern compares every result against the oldest
// prediction. Phases run with several bucket counts and region sizes,
// including the extremes, and with key sets chosen to build long chains.
module chained_set_assoc_hash_table_test;
  import csaht_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [63:0] key;
    logic [15:0] len;
  } op_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] slot;
    logic [15:0] size;
    logic [23:0] offset;
  } answer_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;
  localparam int   IDLE_LIMIT  = 50000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [24:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  chained_set_assoc_hash_table DUT (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // in-bench copy of the table state
  logic [63:0] tbl_keys [SLOT_COUNT];
  logic [15:0] tbl_size [SLOT_COUNT];
  logic [23:0] tbl_off  [SLOT_COUNT];
  int unsigned ovf_taken, fill_bytes;
  logic [8:0]  main_reg;
  logic [24:0] region_reg;

  op_t     pending_ops[$];
  answer_t expected_answers[$];
  int      fails = 0;
  int      sent = 0;
  int      quiet_cycles = 0;

  function automatic answer_t table_apply(op_t op);
    answer_t a;
    int unsigned m, bkt, visits, target, link, sz, lim;
    logic need_new;
    a = '{ST_INSERTED, 12'd0, 16'd0, 24'd0};
    m = (main_reg == 0) ? 1 : 32'(main_reg);
    if (m > TOTAL_BUCKETS - 1) m = TOTAL_BUCKETS - 1;
    need_new = 1'b0;
    target = 0;
    link = 0;
    if (op.key == 0) begin
      a.status = op.mode ? ST_NOT_FOUND : ST_DUPLICATE;
      return a;
    end
    bkt = 32'(op.key % m);
    visits = 0;
    forever begin
      if (visits >= TOTAL_BUCKETS || bkt >= TOTAL_BUCKETS) begin
        a.status = op.mode ? ST_NOT_FOUND : ST_OVF_FULL;
        return a;
      end
      visits++;
      for (int i = 0; i < WAYS - 1; i++) begin
        int unsigned s;
        s = bkt * WAYS + i;
        if (tbl_keys[s] == op.key) begin
          if (op.mode) begin
            a = '{ST_FOUND, s[11:0], tbl_size[s], tbl_off[s]};
          end else begin
            a.status = ST_DUPLICATE;
          end
          return a;
        end
        if (tbl_keys[s] == 0 && !op.mode) begin
          target = s;
          break;
        end
      end
      if (target != 0 || (tbl_keys[bkt*WAYS] == 0 && !op.mode)) break;
      link = bkt * WAYS + WAYS - 1;
      if (tbl_keys[link] == 0) begin
        if (op.mode) begin
          a.status = ST_NOT_FOUND;
          return a;
        end
        need_new = 1'b1;
        break;
      end
      bkt = (tbl_keys[link] >= TOTAL_BUCKETS) ? TOTAL_BUCKETS : 32'(tbl_keys[link]);
    end
    if (need_new && ovf_taken >= TOTAL_BUCKETS - m) begin
      a.status = ST_OVF_FULL;
      return a;
    end
    sz = 32'(op.len) + 1;
    lim = (32'(region_reg) > (1 << OFFSET_BITS)) ? (1 << OFFSET_BITS) : 32'(region_reg);
    if (sz > 16'hFFFF || fill_bytes + sz >= lim) begin
      a.status = ST_VAL_FULL;
      return a;
    end
    if (need_new) begin
      tbl_keys[link] = 64'(m + ovf_taken);
      target = (m + ovf_taken) * WAYS;
      ovf_taken++;
    end
    tbl_keys[target] = op.key;
    tbl_size[target] = sz[15:0];
    tbl_off[target] = fill_bytes[23:0];
    a = '{ST_INSERTED, target[11:0], sz[15:0], fill_bytes[23:0]};
    fill_bytes += sz;
    return a;
  endfunction

  // predictions are made as the stimulus is queued; the table is in order
  task automatic queue_op(logic mode, logic [63:0] key, logic [15:0] len);
    op_t op;
    op = '{mode, key, len};
    pending_ops.push_back(op);
    expected_answers.push_back(table_apply(op));
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_answers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [24:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAIN) main_reg = val[8:0];
    else region_reg = val;
  endtask

  // one phase: a random mix of inserts and lookups, keys mostly in 0..nkeys_mod
  task automatic run_phase(int n, int unsigned nkeys_mod, logic bias_lookup);
    logic [63:0] k;
    for (int i = 0; i < n; i++) begin
      k = (nkeys_mod == 0) ? {$urandom, $urandom} : 64'($urandom_range(nkeys_mod, 0));
      if ($urandom_range(15, 0) == 0) k = {$urandom, $urandom};
      queue_op(($urandom_range(99, 0) < (bias_lookup ? 60 : 30)) ? MODE_LOOKUP : MODE_INSERT,
               k, ($urandom_range(7, 0) == 0) ? 16'($urandom) : 16'($urandom_range(40, 0)));
    end
    wait_drained();
  endtask

  // driver: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(pending_ops.pop_front());
        sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_ops[0].len, pending_ops[0].key};
          s_axis_tuser  <= pending_ops[0].mode;
          if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(30, 0);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: own stall pattern, compare fields
  int stall_phase = 0;
  always @(posedge clk_i) begin
    answer_t got, exp_a;
    if (rst_ni) begin
      stall_phase <= stall_phase + 1;
      m_axis_tready <= ((stall_phase / 64) % 3 == 0) ? 1'b1 : ($urandom_range(3, 0) != 0);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tdata[2:0]);
        got.slot   = m_axis_tdata[14:3];
        got.size   = m_axis_tdata[30:15];
        got.offset = m_axis_tdata[54:31];
        if (expected_answers.size() == 0) begin
          $error("result transaction with nothing expected: %h", m_axis_tdata);
          fails++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (got.status !== exp_a.status) begin
            $error("status exp %0d got %0d", exp_a.status, got.status); fails++;
          end
          if (got.slot !== exp_a.slot) begin
            $error("slot_index exp %0d got %0d", exp_a.slot, got.slot); fails++;
          end
          if (got.size !== exp_a.size) begin
            $error("value_size exp %0d got %0d", exp_a.size, got.size); fails++;
          end
          if (got.offset !== exp_a.offset) begin
            $error("value_offset exp %0d got %0d", exp_a.offset, got.offset); fails++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side; covers the clear sweep
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("chained_set_assoc_hash_table_test NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_keys[i] = '0; tbl_size[i] = '0; tbl_off[i] = '0;
    end
    ovf_taken = 0; fill_bytes = 0;
    main_reg = MAIN_RESET; region_reg = REGION_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero key, extremes, duplicates, miss, big length
    queue_op(MODE_INSERT, 64'd0, 16'd0);
    queue_op(MODE_LOOKUP, 64'd0, 16'd0);
    queue_op(MODE_LOOKUP, 64'd5, 16'd0);
    queue_op(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd65534);
    queue_op(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd3);
    queue_op(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    queue_op(MODE_INSERT, 64'd1, 16'hFFFF);
    queue_op(MODE_INSERT, 64'd1, 16'd0);
    queue_op(MODE_LOOKUP, 64'd1, 16'd0);
    for (int i = 0; i < 9; i++) queue_op(MODE_INSERT, 64'(448 * (i + 1) + 7), 16'(i));
    queue_op(MODE_LOOKUP, 64'(448 * 9 + 7), 16'd0);
    queue_op(MODE_LOOKUP, 64'(448 * 10 + 7), 16'd0);
    wait_drained();

    run_phase(300, 3000, 1'b0);
    // single home bucket: one long chain
    write_reg(CFG_MAIN, 25'd0);
    write_reg(CFG_REGION, 25'h1FF_FFFF);
    run_phase(250, 0, 1'b0);
    // 511 of 512 buckets home, tiny value region
    write_reg(CFG_MAIN, 25'd511);
    write_reg(CFG_REGION, 25'd1);
    run_phase(100, 2000, 1'b1);
    write_reg(CFG_REGION, 25'd20000);
    run_phase(300, 4000, 1'b0);
    write_reg(CFG_MAIN, 25'd37);
    write_reg(CFG_REGION, 25'd16777216);
    run_phase(450, 600, 1'b0);
    write_reg(CFG_MAIN, 25'd448);
    run_phase(430, 0, 1'b1);

    wait_drained();
    if (fails == 0) begin
      $display("chained_set_assoc_hash_table_test OK");
    end else begin
      $display("chained_set_assoc_hash_table_test NOT OK");
    end
    $finish;
  end

endmodule
